>>> src/assert_macros.svh
// Assertion helpers for the RTL. Every check is clocked on i_clk and
// is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// When ante holds, cons must hold in the cycle after.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/stli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_pkg
// Shared types and constants of the sorted table interpolator: field widths,
// result status codes and the controller to datapath command interface.
// ----------------------------------------------------------------------------
package stli_pkg;

    localparam int KEY_W      = 16;
    localparam int VAL_W      = 16;
    localparam int COL_W      = 2;
    localparam int RES_W      = 32;
    localparam int STS_W      = 3;
    localparam int IN_DATA_W  = 40;
    localparam int DIV_STEPS  = 16;
    localparam int DIVCNT_W   = 5;
    localparam int PROD_W     = 34;
    localparam int SUM_W      = 35;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 3'd0,
        STS_CLAMP = 3'd1,
        STS_EMPTY = 3'd2,
        STS_FULL  = 3'd3,
        STS_BUSY  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_STAGE,
        CMD_RES,
        CMD_SCAN_START,
        CMD_RD,
        CMD_STEP,
        CMD_CLAMP_RD,
        CMD_CLAMP_PREV,
        CMD_OVERWRITE,
        CMD_INS_START,
        CMD_RD_PREV,
        CMD_SH_WR,
        CMD_INSERT,
        CMD_DIV_START,
        CMD_DIV_STEP
    } t_cmd;

    typedef struct packed {
        t_cmd    op;
        t_status code;
        logic    mul;
        logic    add;
        logic    out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_write;
        logic row_end;
        logic staging;
        logic empty;
        logic full;
        logic scan_end;
        logic stop;
        logic equal;
        logic at_zero;
        logic sh_done;
        logic div_done;
        logic out_busy;
    } t_dp_sts;

endpackage

>>> src/stli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_ctrl
// Sequencer of the interpolator: decodes each request and steps the
// datapath through table scan, row shift, division and result delivery.
// ----------------------------------------------------------------------------
module stli_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  stli_pkg::t_dp_sts   i_sts,
    output stli_pkg::t_ctrl_cmd o_cmd
);
    import stli_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_DECODE  = 10'b00_0000_0010,
        ST_SCAN_RD = 10'b00_0000_0100,
        ST_SCAN_CK = 10'b00_0000_1000,
        ST_SH_RD   = 10'b00_0001_0000,
        ST_SH_WR   = 10'b00_0010_0000,
        ST_DIV     = 10'b00_0100_0000,
        ST_MUL     = 10'b00_1000_0000,
        ST_ADD     = 10'b01_0000_0000,
        ST_FIN     = 10'b10_0000_0000
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_ctrl_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_cmd.op   = CMD_NONE;
        w_cmd.code = STS_OK;
        w_cmd.mul  = 1'b0;
        w_cmd.add  = 1'b0;
        w_cmd.out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    w_cmd.op = CMD_LOAD;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.is_write) begin
                    w_cmd.op = CMD_STAGE;
                    n_state  = i_sts.row_end ? ST_SCAN_RD : ST_FIN;
                end else if (i_sts.staging) begin
                    w_cmd.op   = CMD_RES;
                    w_cmd.code = STS_BUSY;
                    n_state    = ST_FIN;
                end else if (i_sts.empty) begin
                    w_cmd.op   = CMD_RES;
                    w_cmd.code = STS_EMPTY;
                    n_state    = ST_FIN;
                end else begin
                    w_cmd.op = CMD_SCAN_START;
                    n_state  = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (!i_sts.scan_end) begin
                    w_cmd.op = CMD_RD;
                    n_state  = ST_SCAN_CK;
                end else if (!i_sts.is_write) begin
                    // Key at or past the last row.
                    w_cmd.op = CMD_CLAMP_PREV;
                    n_state  = ST_FIN;
                end else if (i_sts.full) begin
                    w_cmd.op   = CMD_RES;
                    w_cmd.code = STS_FULL;
                    n_state    = ST_FIN;
                end else begin
                    w_cmd.op = CMD_INS_START;
                    n_state  = ST_SH_RD;
                end
            end
            ST_SCAN_CK: begin
                if (!i_sts.stop) begin
                    w_cmd.op = CMD_STEP;
                    n_state  = ST_SCAN_RD;
                end else if (i_sts.is_write) begin
                    if (i_sts.equal) begin
                        w_cmd.op = CMD_OVERWRITE;
                        n_state  = ST_FIN;
                    end else if (i_sts.full) begin
                        w_cmd.op   = CMD_RES;
                        w_cmd.code = STS_FULL;
                        n_state    = ST_FIN;
                    end else begin
                        w_cmd.op = CMD_INS_START;
                        n_state  = ST_SH_RD;
                    end
                end else if (i_sts.at_zero) begin
                    w_cmd.op = CMD_CLAMP_RD;
                    n_state  = ST_FIN;
                end else begin
                    w_cmd.op = CMD_DIV_START;
                    n_state  = ST_DIV;
                end
            end
            ST_SH_RD: begin
                if (i_sts.sh_done) begin
                    w_cmd.op = CMD_INSERT;
                    n_state  = ST_FIN;
                end else begin
                    w_cmd.op = CMD_RD_PREV;
                    n_state  = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                w_cmd.op = CMD_SH_WR;
                n_state  = ST_SH_RD;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_MUL;
                end else begin
                    w_cmd.op = CMD_DIV_STEP;
                end
            end
            ST_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                w_cmd.add = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    w_cmd.out = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd      = w_cmd;
    assign o_s_tready = (r_state == ST_IDLE);

endmodule

>>> src/stli_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stli_dpath
// Datapath of the interpolator: row memory, staging registers, scan index,
// serial divider, multiplier and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module stli_dpath #(
    parameter int DEPTH   = 64,
    parameter int COLUMNS = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  stli_pkg::t_ctrl_cmd                    i_cmd,
    output stli_pkg::t_dp_sts                      o_sts,
    input  logic                                   i_op,
    input  logic signed [stli_pkg::KEY_W-1:0]      i_key,
    input  logic [stli_pkg::COL_W-1:0]             i_col,
    input  logic signed [stli_pkg::VAL_W-1:0]      i_val,
    input  logic                                   i_end,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [stli_pkg::RES_W-1:0]      o_result,
    output logic [stli_pkg::STS_W-1:0]             o_status
);
    import stli_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CLW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW  = VAL_W * COLUMNS + KEY_W;

    // Captured request.
    logic                    r_op;
    logic signed [KEY_W-1:0] r_key;
    logic [COL_W-1:0]        r_col;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_end;

    // Table and staging state.
    logic [RW-1:0]           r_mem [DEPTH];
    logic [RW-1:0]           r_rd_data;
    logic [RW-1:0]           r_prev;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           r_pos;
    logic signed [VAL_W-1:0] r_stg_vals [COLUMNS];
    logic signed [KEY_W-1:0] r_stg_key;
    logic                    r_staging;

    // Interpolation.
    logic [DIV_STEPS:0]      r_rem;
    logic [DIV_STEPS-1:0]    r_quo;
    logic [DIV_STEPS-1:0]    r_dvs;
    logic [DIVCNT_W-1:0]     r_div_cnt;
    logic                    r_neg;
    logic [KEY_W-1:0]        r_dkey;
    logic signed [VAL_W-1:0] r_vlo;
    logic signed [PROD_W-1:0] r_prod;

    // Result.
    logic signed [RES_W-1:0] r_result;
    t_status                 r_status;
    logic                    r_out_valid;
    logic signed [RES_W-1:0] r_out_result;
    logic [STS_W-1:0]        r_out_status;

    logic                    w_col_ok;
    logic [CLW-1:0]          w_scol;
    logic [CLW-1:0]          w_lcol;
    logic [CW-1:0]           w_idx_m1;
    logic [RW-1:0]           w_stg_row;
    logic signed [KEY_W-1:0] w_rd_key;
    logic signed [KEY_W-1:0] w_prev_key;
    logic signed [VAL_W-1:0] w_rd_val;
    logic signed [VAL_W-1:0] w_prev_val;
    logic signed [VAL_W:0]   w_diff;
    logic signed [VAL_W:0]   w_mag;
    logic signed [KEY_W:0]   w_dk;
    logic signed [KEY_W:0]   w_dkey;
    logic [DIV_STEPS:0]      w_rem_sh;
    logic                    w_fit;
    logic signed [VAL_W:0]   w_q;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [RES_W-1:0] w_sat;
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic [RW-1:0]           w_wdata;
    logic                    w_re;
    logic [AW-1:0]           w_raddr;

    assign w_col_ok = (32'(r_col) < COLUMNS);
    assign w_scol   = CLW'(r_col);
    assign w_lcol   = w_col_ok ? CLW'(r_col) : CLW'(COLUMNS - 1);
    assign w_idx_m1 = r_idx - CW'(1);

    always_comb begin
        w_stg_row = '0;
        w_stg_row[KEY_W-1:0] = r_stg_key;
        for (int c = 0; c < COLUMNS; c++) begin
            w_stg_row[KEY_W + VAL_W*c +: VAL_W] = r_stg_vals[c];
        end
    end

    assign w_rd_key   = r_rd_data[KEY_W-1:0];
    assign w_prev_key = r_prev[KEY_W-1:0];
    assign w_rd_val   = r_rd_data[KEY_W + VAL_W*w_lcol +: VAL_W];
    assign w_prev_val = r_prev[KEY_W + VAL_W*w_lcol +: VAL_W];
    assign w_diff     = (VAL_W+1)'(w_rd_val) - (VAL_W+1)'(w_prev_val);
    assign w_mag      = w_diff[VAL_W] ? -w_diff : w_diff;
    assign w_dk       = (KEY_W+1)'(w_rd_key) - (KEY_W+1)'(w_prev_key);
    assign w_dkey     = (KEY_W+1)'(r_key) - (KEY_W+1)'(w_prev_key);

    // Restoring divider, one quotient bit per cycle.
    assign w_rem_sh = {r_rem[DIV_STEPS-1:0], r_quo[DIV_STEPS-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_dvs});

    assign w_q   = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_sum = SUM_W'(r_prod) + SUM_W'(r_vlo);

    always_comb begin
        if (!w_sum[SUM_W-1] && (|w_sum[SUM_W-2:RES_W-1])) begin
            w_sat = {1'b0, {(RES_W-1){1'b1}}};
        end else if (w_sum[SUM_W-1] && !(&w_sum[SUM_W-2:RES_W-1])) begin
            w_sat = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            w_sat = w_sum[RES_W-1:0];
        end
    end

    // Memory port control.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = w_stg_row;
        w_re    = 1'b0;
        w_raddr = r_idx[AW-1:0];
        case (i_cmd.op)
            CMD_OVERWRITE: begin
                w_we = 1'b1;
            end
            CMD_INSERT: begin
                w_we    = 1'b1;
                w_waddr = r_pos[AW-1:0];
            end
            CMD_SH_WR: begin
                w_we    = 1'b1;
                w_wdata = r_rd_data;
            end
            CMD_RD: begin
                w_re = 1'b1;
            end
            CMD_RD_PREV: begin
                w_re    = 1'b1;
                w_raddr = w_idx_m1[AW-1:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_staging   <= 1'b0;
            r_stg_key   <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < COLUMNS; c++) begin
                r_stg_vals[c] <= '0;
            end
        end else begin
            if (i_cmd.op == CMD_STAGE) begin
                r_staging <= 1'b1;
                r_stg_key <= r_key;
                if (w_col_ok) begin
                    r_stg_vals[w_scol] <= r_val;
                end
            end
            if (i_cmd.op == CMD_INSERT) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.out && r_op && r_end) begin
                r_staging <= 1'b0;
                for (int c = 0; c < COLUMNS; c++) begin
                    r_stg_vals[c] <= '0;
                end
            end
            if (i_cmd.out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_LOAD: begin
                r_op  <= i_op;
                r_key <= i_key;
                r_col <= i_col;
                r_val <= i_val;
                r_end <= i_end;
            end
            CMD_STAGE: begin
                r_idx    <= '0;
                r_result <= '0;
                r_status <= STS_OK;
            end
            CMD_RES: begin
                r_result <= '0;
                r_status <= i_cmd.code;
            end
            CMD_SCAN_START: begin
                r_idx <= '0;
            end
            CMD_STEP: begin
                r_prev <= r_rd_data;
                r_idx  <= r_idx + CW'(1);
            end
            CMD_CLAMP_RD: begin
                r_result <= RES_W'(w_rd_val);
                r_status <= STS_CLAMP;
            end
            CMD_CLAMP_PREV: begin
                r_result <= RES_W'(w_prev_val);
                r_status <= STS_CLAMP;
            end
            CMD_INS_START: begin
                r_pos <= r_idx;
                r_idx <= r_count;
            end
            CMD_SH_WR: begin
                r_idx <= w_idx_m1;
            end
            CMD_DIV_START: begin
                r_rem     <= '0;
                r_quo     <= w_mag[DIV_STEPS-1:0];
                r_neg     <= w_diff[VAL_W];
                r_dvs     <= w_dk[DIV_STEPS-1:0];
                r_dkey    <= w_dkey[KEY_W-1:0];
                r_vlo     <= w_prev_val;
                r_div_cnt <= DIVCNT_W'(DIV_STEPS);
            end
            CMD_DIV_STEP: begin
                r_rem     <= w_fit ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
                r_quo     <= {r_quo[DIV_STEPS-2:0], w_fit};
                r_div_cnt <= r_div_cnt - DIVCNT_W'(1);
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
        if (i_cmd.mul) begin
            r_prod <= w_q * $signed({1'b0, r_dkey});
        end
        if (i_cmd.add) begin
            r_result <= w_sat;
            r_status <= STS_OK;
        end
        if (i_cmd.out) begin
            r_out_result <= r_result;
            r_out_status <= r_status;
        end
    end

    always_comb begin
        o_sts.is_write = r_op;
        o_sts.row_end  = r_end;
        o_sts.staging  = r_staging;
        o_sts.empty    = (r_count == '0);
        o_sts.full     = (r_count == CW'(DEPTH));
        o_sts.scan_end = (r_idx == r_count);
        o_sts.stop     = r_op ? (w_rd_key >= r_stg_key) : (w_rd_key > r_key);
        o_sts.equal    = (w_rd_key == r_stg_key);
        o_sts.at_zero  = (r_idx == '0);
        o_sts.sh_done  = (r_idx == r_pos);
        o_sts.div_done = (r_div_cnt == '0);
        o_sts.out_busy = r_out_valid && !i_ready;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_result;
    assign o_status = r_out_status;

    `ASSERT_ALWAYS(a_count_bound, r_count <= CW'(DEPTH), "row count exceeds table depth")
    `ASSERT_NEXT(a_insert_grows, i_cmd.op == CMD_INSERT, r_count == $past(r_count) + CW'(1), "insert did not grow the table")
    `ASSERT_ALWAYS(a_shift_range, (i_cmd.op != CMD_SH_WR) || ((r_idx > r_pos) && (r_idx <= r_count)), "row shift outside the live table")
    `ASSERT_NEXT(a_full_drop, (i_cmd.op == CMD_RES) && (i_cmd.code == STS_FULL), r_count == CW'(DEPTH), "full drop with free rows")

endmodule

>>> src/sorted_table_linear_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_core
// Key-sorted row table with write staging and piecewise linear lookup.
// ----------------------------------------------------------------------------
// One request is handled at a time; the table lives in a row memory with
// separate read and write ports, one row per word; scan and shift spend a
// read state and a check or write state on each row. A plain write only
// stages a column. A lookup scans rows until it passes the key, then runs
// the serial divider, a multiply and an add; a committing write overwrites
// a row of equal key, or scans to place p and shifts the rows from p up. The
// next request is taken while a result waits in the output register.
module sorted_table_linear_interpolator_core #(
    parameter int DEPTH   = 64,
    parameter int COLUMNS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // key [15:0], column [17:16], value [33:18], zero [39:34]
    input  logic [stli_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // operation [0]
    input  logic                                i_s_tuser,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // result [31:0]
    output logic [stli_pkg::RES_W-1:0]          o_m_tdata,
    // status [2:0]
    output logic [stli_pkg::STS_W-1:0]          o_m_tuser
);
    import stli_pkg::*;

    t_ctrl_cmd w_cmd;
    t_dp_sts   w_sts;
    logic signed [RES_W-1:0] w_result;

    stli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    stli_dpath #(
        .DEPTH   (DEPTH),
        .COLUMNS (COLUMNS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_op     (i_s_tuser),
        .i_key    (i_s_tdata[15:0]),
        .i_col    (i_s_tdata[17:16]),
        .i_val    (i_s_tdata[33:18]),
        .i_end    (i_s_tlast),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result),
        .o_status (o_m_tuser)
    );

    assign o_m_tdata = w_result;

endmodule

>>> test/sorted_table_linear_interpolator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_core_tb
// Drives row writes and lookups into the interpolator and checks every result
// and status against a behavioral table kept in the scoreboard.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_core_tb;
    import stli_pkg::*;

    localparam int DEPTH    = 64;
    localparam int COLUMNS  = 4;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] result;
        t_status            status;
    } t_lookup_out;

    // Behavioral copy of the table; computes the response of each request.
    class interp_scoreboard;
        int          keys [DEPTH];
        int          vals [DEPTH][COLUMNS];
        int          rows;
        int          stage_vals [COLUMNS];
        int          stage_key;
        bit          staging;
        t_lookup_out pending [$];
        int          errors;

        function void clear();
            rows = 0;
            stage_key = 0;
            staging = 0;
            foreach (stage_vals[c]) stage_vals[c] = 0;
            errors = 0;
        endfunction

        function t_status commit_row();
            int pos;
            pos = 0;
            while (pos < rows && keys[pos] < stage_key) pos++;
            if (pos < rows && keys[pos] == stage_key) begin
                for (int c = 0; c < COLUMNS; c++) vals[pos][c] = stage_vals[c];
                return STS_OK;
            end
            if (rows >= DEPTH) return STS_FULL;
            for (int i = rows; i > pos; i--) begin
                keys[i] = keys[i-1];
                for (int c = 0; c < COLUMNS; c++) vals[i][c] = vals[i-1][c];
            end
            keys[pos] = stage_key;
            for (int c = 0; c < COLUMNS; c++) vals[pos][c] = stage_vals[c];
            rows++;
            return STS_OK;
        endfunction

        function void note_request(bit wr, logic signed [15:0] key, logic [1:0] col,
                                   logic signed [15:0] val, bit row_end);
            t_lookup_out o;
            int   lo, c;
            longint q, r;
            o.result = 0;
            o.status = STS_OK;
            c = col;
            if (wr) begin
                staging = 1;
                stage_key = key;
                if (c < COLUMNS) stage_vals[c] = val;
                if (row_end) begin
                    o.status = commit_row();
                    foreach (stage_vals[i]) stage_vals[i] = 0;
                    staging = 0;
                end
            end else if (staging) begin
                o.status = STS_BUSY;
            end else if (rows == 0) begin
                o.status = STS_EMPTY;
            end else begin
                if (c >= COLUMNS) c = COLUMNS - 1;
                if (key < keys[0]) begin
                    o.result = vals[0][c];
                    o.status = STS_CLAMP;
                end else if (key >= keys[rows-1]) begin
                    o.result = vals[rows-1][c];
                    o.status = STS_CLAMP;
                end else begin
                    lo = 0;
                    while (lo + 1 < rows && keys[lo+1] <= key) lo++;
                    q = (longint'(vals[lo+1][c]) - vals[lo][c]) / (keys[lo+1] - keys[lo]);
                    r = q * (longint'(key) - keys[lo]) + vals[lo][c];
                    if (r > 64'sd2147483647) r = 64'sd2147483647;
                    if (r < -64'sd2147483648) r = -64'sd2147483648;
                    o.result = r[31:0];
                end
            end
            pending.push_back(o);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [31:0] res, logic [2:0] sts);
            t_lookup_out e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d status %0d", res, sts));
                return;
            end
            e = pending.pop_front();
            if (res !== e.result)
                report_mismatch($sformatf("result %0d, expected %0d", $signed(res),
                                          e.result));
            if (sts !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", sts, e.status));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [39:0] s_data = '0;
    logic        s_user = 0;
    logic        s_last = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_data;
    logic [2:0]  m_user;

    interp_scoreboard sb;
    int  idle_cycles = 0;
    bit  hold_sink;

    sorted_table_linear_interpolator_core #(.DEPTH(DEPTH), .COLUMNS(COLUMNS)) u_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_valid),
        .o_s_tready(s_ready),
        .i_s_tdata (s_data),
        .i_s_tuser (s_user),
        .i_s_tlast (s_last),
        .o_m_tvalid(m_valid),
        .i_m_tready(m_ready),
        .o_m_tdata (m_data),
        .o_m_tuser (m_user)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    // Sends one request and waits for it to be taken. The valid stays high
    // after acceptance so that a zero gap gives back to back requests.
    task automatic send_request(bit wr, logic [15:0] key, logic [1:0] col,
                                logic [15:0] val, bit row_end);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= wr;
        s_last  <= row_end;
        s_data  <= {6'b0, val, col, key};
        do @(posedge clk); while (!s_ready);
        sb.note_request(wr, key, col, val, row_end);
    endtask

    task automatic write_row(logic [15:0] key, bit random_cols);
        for (int c = 0; c < COLUMNS; c++)
            if (!random_cols || $urandom_range(0, 3) != 0)
                send_request(1'b1, key, c[1:0], 16'($urandom()), 1'b0);
        send_request(1'b1, key, 2'($urandom()), 16'($urandom()), 1'b1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Keys mostly from a narrow window so that rows get revisited and lookups
    // land between rows.
    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 3) == 0) return 16'($urandom());
        return 16'($signed($urandom_range(0, 400)) - 200);
    endfunction

    // Result sink with random stalls.
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) sb.check_result(m_data, m_user);
        if (hold_sink) m_ready <= 0;
        else if ($urandom_range(0, 99) < 15) m_ready <= 0;
        else m_ready <= 1;
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT && !hold_sink) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        sb = new();
        sb.clear();
        hold_sink = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty table, extremes, busy lookup, out-of-range ends.
        send_request(1'b0, 16'h0000, 2'd0, 16'h0, 1'b0);
        send_request(1'b1, 16'h8000, 2'd0, 16'h7FFF, 1'b0);
        send_request(1'b0, 16'h0000, 2'd1, 16'hFFFF, 1'b1);
        send_request(1'b1, 16'h8000, 2'd3, 16'h8000, 1'b1);
        send_request(1'b1, 16'h7FFF, 2'd0, 16'h8000, 1'b0);
        send_request(1'b1, 16'h7FFF, 2'd3, 16'h7FFF, 1'b1);
        send_request(1'b0, 16'h8000, 2'd0, 16'h0, 1'b0);
        send_request(1'b0, 16'h7FFF, 2'd3, 16'h0, 1'b0);
        send_request(1'b0, 16'h0000, 2'd0, 16'h0, 1'b0);
        send_request(1'b0, 16'h8001, 2'd3, 16'h0, 1'b0);
        send_request(1'b0, 16'h7FFE, 2'd2, 16'h0, 1'b1);
        send_request(1'b1, 16'h0000, 2'd1, 16'h1234, 1'b1);
        send_request(1'b0, 16'h0001, 2'd1, 16'h0, 1'b0);
        send_request(1'b0, 16'hFFFF, 2'd1, 16'h0, 1'b0);
        send_request(1'b1, 16'h0000, 2'd2, 16'h5555, 1'b1);
        send_request(1'b0, 16'h0000, 2'd2, 16'h0, 1'b0);
        drain();

        // Random rows and lookups; the table overflows along the way.
        for (int n = 0; n < 80; n++) begin
            if ($urandom_range(0, 9) == 0)
                send_request(1'b1, pick_key(), 2'($urandom()), 16'($urandom()),
                             1'($urandom()));
            else write_row(pick_key(), 1'b1);
            repeat ($urandom_range(1, 3))
                send_request(1'b0, pick_key(), 2'($urandom()), 16'($urandom()),
                             1'($urandom()));
            if (n == 30) drain();
            if (n == 60) begin
                hold_sink = 1;
                fork
                    begin
                        repeat (400) @(posedge clk);
                        hold_sink = 0;
                    end
                join_none
            end
        end
        drain();
        repeat (300) @(posedge clk);
        if (sb.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
